FILE: design/load_switch_and_fan_controller_defines.svh
// ----------------------------------------------------------------------------
// load switch and fan controller: assertion macros
// shared concurrent checks, clocked on clk and quiet while in reset
// ----------------------------------------------------------------------------
`ifndef LOAD_SWITCH_AND_FAN_CONTROLLER_DEFINES_SVH
`define LOAD_SWITCH_AND_FAN_CONTROLLER_DEFINES_SVH

// condition holds in the same cycle
`define LSFC_ASSERT_SAME(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// condition holds in the following cycle
`define LSFC_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

FILE: design/lsfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfc_pkg
// types, codes and helper functions of the load switch and fan controller
// ----------------------------------------------------------------------------
package lsfc_pkg;

    localparam int SWITCH_COUNT_DEFAULT = 3;
    localparam int MASK_WIDTH           = 3;
    localparam int DUTY_WIDTH           = 7;
    localparam int PWM_WIDTH            = 8;
    localparam int TICKS_WIDTH          = 16;

    localparam logic [TICKS_WIDTH-1:0] CYCLE_TICKS_RESET = 16'd3000;
    localparam logic [TICKS_WIDTH-1:0] ELAPSED_MAX       = 16'hFFFF;

    localparam logic [7:0] CMD_ON         = 8'd1;
    localparam logic [7:0] CMD_CYCLE      = 8'd2;
    localparam logic [7:0] FAN_MODE_CURVE = 8'd0;

    localparam logic [DUTY_WIDTH-1:0] DUTY_MAX     = 7'd100;
    localparam logic [DUTY_WIDTH-1:0] DUTY_LOW_KNEE = 7'd25;
    localparam logic [DUTY_WIDTH-1:0] DUTY_MID_KNEE = 7'd75;

    // 30.0, 40.0 and 50.0 degC in tenths
    localparam logic signed [15:0] TEMP_LOW  = 16'sd300;
    localparam logic signed [15:0] TEMP_MID  = 16'sd400;
    localparam logic signed [15:0] TEMP_HIGH = 16'sd500;

    // ceil(255 * 2^22 / 100), exact floor for every duty up to 100
    localparam logic [23:0] PWM_RECIP = 24'd10695476;

    typedef enum logic [2:0] {
        KIND_SET_DEVICE = 3'd0,
        KIND_SET_FAN    = 3'd1,
        KIND_TICK       = 3'd2,
        KIND_TEMP       = 3'd3,
        KIND_STATUS     = 3'd4
    } kind_t;

    typedef struct packed {
        logic       apply;
        kind_t      kind;
        logic [7:0] switch_index;
        logic [7:0] device_command;
    } switch_cmd_t;

    typedef struct packed {
        logic [MASK_WIDTH-1:0] mask;
        logic                  device_invalid;
    } switch_status_t;

    typedef struct packed {
        logic                  ack_valid;
        logic                  ack_status;
        logic [MASK_WIDTH-1:0] switch_mask;
        logic [DUTY_WIDTH-1:0] fan_duty_percent;
        logic [PWM_WIDTH-1:0]  fan_pwm_level;
    } result_t;

    function automatic logic [DUTY_WIDTH-1:0] curve_duty(input logic signed [15:0] t);
        logic signed [16:0]    off_low;
        logic signed [16:0]    off_mid;
        logic [DUTY_WIDTH-1:0] d;
        off_low = 17'(t) - 17'(TEMP_LOW);
        off_mid = 17'(t) - 17'(TEMP_MID);
        if (t < TEMP_LOW)
            d = '0;
        else if (t < TEMP_MID)
            d = DUTY_LOW_KNEE + 7'(off_low[7:1]);
        else if (t < TEMP_HIGH)
            d = DUTY_MID_KNEE + 7'(off_mid[8:2]);
        else
            d = DUTY_MAX;
        return d;
    endfunction

    function automatic logic [PWM_WIDTH-1:0] pwm_level(input logic [DUTY_WIDTH-1:0] duty);
        logic [30:0] prod;
        prod = 31'(duty) * 31'(PWM_RECIP);
        return prod[29:22];
    endfunction

endpackage

FILE: design/load_switch_and_fan_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_switch_and_fan_controller
// Takes one command, tick or temperature sample per clock while in_stall is
// low and returns one result per item, carrying the state after that item.
// The output side holds a result register and one skid entry, so one more
// input transfer is taken while a single result waits; in_stall rises
// only when both are occupied. The power cycle length is written through
// the cfg port, which is always ready and should only be written while no
// items are in flight.
// ----------------------------------------------------------------------------
module load_switch_and_fan_controller #(
    parameter int SWITCH_COUNT = lsfc_pkg::SWITCH_COUNT_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lsfc_pkg::TICKS_WIDTH-1:0]     power_cycle_ticks,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [2:0]                           kind,
    input  logic [7:0]                           switch_index,
    input  logic [7:0]                           device_command,
    input  logic [7:0]                           fan_mode,
    input  logic [7:0]                           manual_duty,
    input  logic signed [15:0]                   temperature_tenths,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 ack_valid,
    output logic                                 ack_status,
    output logic [lsfc_pkg::MASK_WIDTH-1:0]      switch_mask,
    output logic [lsfc_pkg::DUTY_WIDTH-1:0]      fan_duty_percent,
    output logic [lsfc_pkg::PWM_WIDTH-1:0]       fan_pwm_level
);

`include "load_switch_and_fan_controller_defines.svh"

    logic [lsfc_pkg::TICKS_WIDTH-1:0] cycle_ticks_reg;
    logic                             auto_reg;
    logic                             auto_next;
    logic [lsfc_pkg::DUTY_WIDTH-1:0]  manual_reg;
    logic [lsfc_pkg::DUTY_WIDTH-1:0]  manual_next;
    logic [lsfc_pkg::DUTY_WIDTH-1:0]  duty_reg;
    logic [lsfc_pkg::DUTY_WIDTH-1:0]  duty_next;
    logic                             out_valid_reg;
    logic                             skid_valid_reg;
    lsfc_pkg::result_t                out_reg;
    lsfc_pkg::result_t                skid_reg;
    lsfc_pkg::result_t                result_next;
    lsfc_pkg::kind_t                  kind_in;
    lsfc_pkg::switch_cmd_t            sw_cmd;
    lsfc_pkg::switch_status_t         sw_status;
    logic                             accept;
    logic                             out_take;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign kind_in   = lsfc_pkg::kind_t'(kind);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycle_ticks_reg <= lsfc_pkg::CYCLE_TICKS_RESET;
        else if (cfg_valid && cfg_ready)
            cycle_ticks_reg <= power_cycle_ticks;
    end

    assign sw_cmd.apply          = accept;
    assign sw_cmd.kind           = kind_in;
    assign sw_cmd.switch_index   = switch_index;
    assign sw_cmd.device_command = device_command;

    lsfc_switch_bank #(
        .SWITCH_COUNT (SWITCH_COUNT)
    ) u_switch_bank (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (sw_cmd),
        .cycle_ticks (cycle_ticks_reg),
        .status      (sw_status)
    );

    // fan mode, stored manual duty and current duty
    always_comb
    begin
        auto_next   = auto_reg;
        manual_next = manual_reg;
        duty_next   = duty_reg;
        if (accept)
        begin
            case (kind_in)
                lsfc_pkg::KIND_SET_FAN:
                begin
                    if (fan_mode == lsfc_pkg::FAN_MODE_CURVE)
                        auto_next = 1'b1;
                    else
                    begin
                        auto_next   = 1'b0;
                        manual_next = (manual_duty > 8'(lsfc_pkg::DUTY_MAX))
                                      ? lsfc_pkg::DUTY_MAX : manual_duty[6:0];
                    end
                end
                lsfc_pkg::KIND_TEMP:
                    duty_next = auto_reg ? lsfc_pkg::curve_duty(temperature_tenths)
                                         : manual_reg;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg   <= 1'b1;
            manual_reg <= '0;
            duty_reg   <= '0;
        end
        else
        begin
            auto_reg   <= auto_next;
            manual_reg <= manual_next;
            duty_reg   <= duty_next;
        end
    end

    always_comb
    begin
        result_next.ack_valid        = 1'b0;
        result_next.ack_status       = 1'b0;
        result_next.switch_mask      = sw_status.mask;
        result_next.fan_duty_percent = duty_next;
        result_next.fan_pwm_level    = lsfc_pkg::pwm_level(duty_next);
        case (kind_in)
            lsfc_pkg::KIND_SET_DEVICE:
            begin
                result_next.ack_valid  = 1'b1;
                result_next.ack_status = sw_status.device_invalid;
            end
            lsfc_pkg::KIND_SET_FAN,
            lsfc_pkg::KIND_STATUS:
                result_next.ack_valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    // result register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
                skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_take)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_take)
                skid_reg <= result_next;
            else
                out_reg <= result_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign ack_valid        = out_reg.ack_valid;
    assign ack_status       = out_reg.ack_status;
    assign switch_mask      = out_reg.switch_mask;
    assign fan_duty_percent = out_reg.fan_duty_percent;
    assign fan_pwm_level    = out_reg.fan_pwm_level;

    `LSFC_ASSERT_SAME(a_skid_needs_out, skid_valid_reg, out_valid_reg, "skid entry without result")
    `LSFC_ASSERT_NEXT(a_accept_gives_out, accept, out_valid_reg, "transfer in gave no result")
    `LSFC_ASSERT_SAME(a_duty_in_range, 1'b1, duty_reg <= lsfc_pkg::DUTY_MAX, "fan duty above max")
    `LSFC_ASSERT_NEXT(a_held_result_stays, out_valid_reg && out_stall, out_valid_reg, "held result lost")

endmodule

FILE: design/lsfc_switch_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfc_switch_bank
// switch states and power cycle counters, updated once per transfer
// ----------------------------------------------------------------------------
module lsfc_switch_bank #(
    parameter int SWITCH_COUNT = lsfc_pkg::SWITCH_COUNT_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lsfc_pkg::switch_cmd_t               cmd,
    input  logic [lsfc_pkg::TICKS_WIDTH-1:0]    cycle_ticks,
    output lsfc_pkg::switch_status_t            status
);

    logic [SWITCH_COUNT-1:0] on_next;
    logic                    id_valid;

    assign id_valid = (cmd.switch_index < 8'(SWITCH_COUNT));

    for (genvar g = 0; g < SWITCH_COUNT; g++) begin : g_switch
        logic                             on_reg;
        logic                             on_nx;
        logic                             active_reg;
        logic                             active_next;
        logic [lsfc_pkg::TICKS_WIDTH-1:0] elapsed_reg;
        logic [lsfc_pkg::TICKS_WIDTH-1:0] elapsed_next;
        logic [lsfc_pkg::TICKS_WIDTH-1:0] bumped;

        always_comb
        begin
            bumped       = (elapsed_reg == lsfc_pkg::ELAPSED_MAX) ? elapsed_reg
                                                                  : elapsed_reg + 16'd1;
            on_nx        = on_reg;
            active_next  = active_reg;
            elapsed_next = elapsed_reg;
            if (cmd.apply)
            begin
                case (cmd.kind)
                    lsfc_pkg::KIND_SET_DEVICE:
                    begin
                        if (id_valid && (cmd.switch_index == 8'(g)))
                        begin
                            if (cmd.device_command == lsfc_pkg::CMD_CYCLE)
                            begin
                                on_nx        = 1'b0;
                                active_next  = 1'b1;
                                elapsed_next = '0;
                            end
                            else
                            begin
                                on_nx       = (cmd.device_command == lsfc_pkg::CMD_ON);
                                active_next = 1'b0;
                            end
                        end
                    end
                    lsfc_pkg::KIND_TICK:
                    begin
                        if (active_reg)
                        begin
                            elapsed_next = bumped;
                            if (bumped >= cycle_ticks)
                            begin
                                on_nx       = 1'b1;
                                active_next = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                on_reg      <= 1'b0;
                active_reg  <= 1'b0;
                elapsed_reg <= '0;
            end
            else
            begin
                on_reg      <= on_nx;
                active_reg  <= active_next;
                elapsed_reg <= elapsed_next;
            end
        end

        assign on_next[g] = on_nx;
    end

    // only the low switches are visible in the mask
    for (genvar k = 0; k < lsfc_pkg::MASK_WIDTH; k++) begin : g_mask
        if (k < SWITCH_COUNT) begin : g_used
            assign status.mask[k] = on_next[k];
        end
        else begin : g_unused
            assign status.mask[k] = 1'b0;
        end
    end

    assign status.device_invalid = !id_valid;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the load switch and fan controller. A short table
// of commands, ticks and temperature samples runs first, with fixed results
// where they are obvious. Random traffic then runs in phases, each with a
// power cycle length written at its start. Both handshakes idle at random, and the output is
// held off for long stretches so that the input stalls. Every result
// without a fixed one is compared with a behavioural model of the
// switches, the power cycles and the fan curve.
// ----------------------------------------------------------------------------
module tb_top;
    import lsfc_pkg::*;

    localparam int         NUM_SWITCHES   = SWITCH_COUNT_DEFAULT;
    localparam int         GAP_MAX        = 17;
    localparam int         LONG_HOLD      = 60;
    localparam int         PHASES         = 5;
    localparam int         PHASE_ITEMS    = 265;
    localparam logic [7:0] CMD_OFF        = 8'd0;
    localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI  = 3'd7;
    localparam logic       ACK_ACCEPTED   = 1'b0;
    localparam logic       ACK_BAD_DEVICE = 1'b1;

    typedef struct {
        logic [2:0]         kind;
        logic [7:0]         switch_index;
        logic [7:0]         device_command;
        logic [7:0]         fan_mode;
        logic [7:0]         manual_duty;
        logic signed [15:0] temp;
    } ctl_item_t;

    typedef struct {
        ctl_item_t item;
        bit        known;
        result_t   res;
    } table_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [TICKS_WIDTH-1:0]  power_cycle_ticks;
    logic                    in_valid;
    logic                    in_stall;
    logic [2:0]              kind;
    logic [7:0]              switch_index;
    logic [7:0]              device_command;
    logic [7:0]              fan_mode;
    logic [7:0]              manual_duty;
    logic signed [15:0]      temperature_tenths;
    logic                    out_valid;
    logic                    out_stall;
    logic                    ack_valid;
    logic                    ack_status;
    logic [MASK_WIDTH-1:0]   switch_mask;
    logic [DUTY_WIDTH-1:0]   fan_duty_percent;
    logic [PWM_WIDTH-1:0]    fan_pwm_level;

    // model state
    logic [TICKS_WIDTH-1:0]  m_cycle_len;
    bit                      m_on      [NUM_SWITCHES];
    bit                      m_cycling [NUM_SWITCHES];
    logic [TICKS_WIDTH-1:0]  m_elapsed [NUM_SWITCHES];
    bit                      m_auto;
    logic [DUTY_WIDTH-1:0]   m_manual;
    logic [DUTY_WIDTH-1:0]   m_duty;

    result_t pending_status[$];
    int      errors;
    int      items_sent;
    int      results_seen;
    int      input_stalls;
    int      cycles_done;
    int      cfg_writes;
    bit      tx_burst;

    load_switch_and_fan_controller #(
        .SWITCH_COUNT(NUM_SWITCHES)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .power_cycle_ticks  (power_cycle_ticks),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .kind               (kind),
        .switch_index       (switch_index),
        .device_command     (device_command),
        .fan_mode           (fan_mode),
        .manual_duty        (manual_duty),
        .temperature_tenths (temperature_tenths),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .ack_valid          (ack_valid),
        .ack_status         (ack_status),
        .switch_mask        (switch_mask),
        .fan_duty_percent   (fan_duty_percent),
        .fan_pwm_level      (fan_pwm_level)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0d want %0d (result %0d)",
                                      name, got, want, results_seen));
        end
    endtask

    function automatic logic [DUTY_WIDTH-1:0] fan_curve(input logic signed [15:0] t);
        int tv;
        tv = t;
        if (tv < int'(TEMP_LOW))
            return '0;
        if (tv < int'(TEMP_MID))
            return DUTY_WIDTH'(int'(DUTY_LOW_KNEE) + (tv - int'(TEMP_LOW)) / 2);
        if (tv < int'(TEMP_HIGH))
            return DUTY_WIDTH'(int'(DUTY_MID_KNEE) + (tv - int'(TEMP_MID)) / 4);
        return DUTY_MAX;
    endfunction

    // applies one item to the model and returns the status after it
    task automatic predict_status(input ctl_item_t it, output result_t r);
        int i;
        r = '0;
        case (it.kind)
            KIND_SET_DEVICE:
            begin
                r.ack_valid = 1'b1;
                if (it.switch_index >= NUM_SWITCHES)
                begin
                    r.ack_status = ACK_BAD_DEVICE;
                end
                else if (it.device_command == CMD_CYCLE)
                begin
                    m_on[it.switch_index]      = 1'b0;
                    m_cycling[it.switch_index] = 1'b1;
                    m_elapsed[it.switch_index] = '0;
                end
                else
                begin
                    m_on[it.switch_index]      = (it.device_command == CMD_ON);
                    m_cycling[it.switch_index] = 1'b0;
                end
            end
            KIND_SET_FAN:
            begin
                r.ack_valid = 1'b1;
                if (it.fan_mode == FAN_MODE_CURVE)
                begin
                    m_auto = 1'b1;
                end
                else
                begin
                    m_auto   = 1'b0;
                    m_manual = (it.manual_duty > DUTY_MAX) ? DUTY_MAX
                                                           : DUTY_WIDTH'(it.manual_duty);
                end
            end
            KIND_TICK:
            begin
                for (i = 0; i < NUM_SWITCHES; i++)
                begin
                    if (m_cycling[i])
                    begin
                        if (m_elapsed[i] != ELAPSED_MAX)
                            m_elapsed[i]++;
                        if (m_elapsed[i] >= m_cycle_len)
                        begin
                            m_on[i]      = 1'b1;
                            m_cycling[i] = 1'b0;
                            cycles_done++;
                        end
                    end
                end
            end
            KIND_TEMP:
            begin
                m_duty = m_auto ? fan_curve(it.temp) : m_manual;
            end
            KIND_STATUS:
            begin
                r.ack_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
        for (i = 0; i < NUM_SWITCHES && i < MASK_WIDTH; i++)
        begin
            r.switch_mask[i] = m_on[i];
        end
        r.fan_duty_percent = m_duty;
        r.fan_pwm_level    = PWM_WIDTH'((int'(m_duty) * 255) / 100);
    endtask

    function automatic result_t status_word(input logic av, input logic st,
                                            input logic [MASK_WIDTH-1:0] mask,
                                            input logic [DUTY_WIDTH-1:0] duty,
                                            input logic [PWM_WIDTH-1:0] pwm);
        result_t r;
        r.ack_valid        = av;
        r.ack_status       = st;
        r.switch_mask      = mask;
        r.fan_duty_percent = duty;
        r.fan_pwm_level    = pwm;
        return r;
    endfunction

    function automatic table_row_t row(input logic [2:0] k, input logic [7:0] id,
                                       input logic [7:0] cmd, input logic [7:0] mode,
                                       input logic [7:0] duty, input logic signed [15:0] t,
                                       input bit known, input result_t res);
        table_row_t w;
        w.item.kind           = k;
        w.item.switch_index   = id;
        w.item.device_command = cmd;
        w.item.fan_mode       = mode;
        w.item.manual_duty    = duty;
        w.item.temp           = t;
        w.known               = known;
        w.res                 = res;
        return w;
    endfunction

    function automatic ctl_item_t random_item(input int tick_pct);
        ctl_item_t it;
        int        pick;
        it.kind           = 3'($urandom);
        it.switch_index   = 8'($urandom);
        it.device_command = 8'($urandom);
        it.fan_mode       = 8'($urandom);
        it.manual_duty    = 8'($urandom);
        it.temp           = 16'($urandom);
        if ($urandom_range(0, 99) < tick_pct)
        begin
            it.kind = KIND_TICK;
        end
        else
        begin
            pick = $urandom_range(0, 19);
            if (pick < 8)
            begin
                it.kind = KIND_SET_DEVICE;
                if ($urandom_range(0, 7) != 0)
                    it.switch_index = 8'($urandom_range(0, NUM_SWITCHES - 1));
                if ($urandom_range(0, 5) != 0)
                    it.device_command = 8'($urandom_range(CMD_OFF, CMD_CYCLE));
            end
            else if (pick < 12)
            begin
                it.kind = KIND_TEMP;
                if ($urandom_range(0, 4) != 0)
                    it.temp = 16'($urandom_range(200, 600));
            end
            else if (pick < 15)
            begin
                it.kind = KIND_SET_FAN;
                if ($urandom_range(0, 2) == 0)
                    it.fan_mode = FAN_MODE_CURVE;
                if ($urandom_range(0, 1) == 0)
                    it.manual_duty = 8'($urandom_range(0, 110));
            end
            else if (pick < 17)
            begin
                it.kind = KIND_STATUS;
            end
            else
            begin
                it.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            end
        end
        return it;
    endfunction

    // offers one item, waits for its transfer, then idles for a drawn gap
    task automatic issue(input ctl_item_t it, input bit known, input result_t known_res);
        result_t r;
        int      gap;
        kind               <= it.kind;
        switch_index       <= it.switch_index;
        device_command     <= it.device_command;
        fan_mode           <= it.fan_mode;
        manual_duty        <= it.manual_duty;
        temperature_tenths <= it.temp;
        in_valid           <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (in_stall === 1'b0)
                break;
            input_stalls++;
        end
        predict_status(it, r);
        pending_status.push_back(known ? known_res : r);
        items_sent++;
        if (items_sent % 40 == 0)
            tx_burst = ($urandom_range(0, 3) == 0);
        gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_cycle_len(input logic [TICKS_WIDTH-1:0] len);
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid         <= 1'b1;
        power_cycle_ticks <= len;
        forever
        begin
            @(posedge clk);
            if (cfg_ready === 1'b1)
                break;
        end
        cfg_valid   <= 1'b0;
        m_cycle_len = len;
        cfg_writes++;
    endtask

    // result checking
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_status.size() == 0)
            begin
                report_mismatch("result with nothing pending");
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("ack_valid", 8'(ack_valid), 8'(want.ack_valid));
                check_field("ack_status", 8'(ack_status), 8'(want.ack_status));
                check_field("switch_mask", 8'(switch_mask), 8'(want.switch_mask));
                check_field("fan_duty_percent", 8'(fan_duty_percent),
                            8'(want.fan_duty_percent));
                check_field("fan_pwm_level", fan_pwm_level, want.fan_pwm_level);
                results_seen++;
            end
        end
    end

    // receiver: random stall before each transfer, with an occasional long hold
    initial
    begin
        int hold;
        int xfers;
        bit rx_burst;
        xfers     = 0;
        rx_burst  = 1'b0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (xfers % 40 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (xfers % 300 == 150)
                hold = LONG_HOLD;
            else if (rx_burst)
                hold = 0;
            else
                hold = $urandom_range(0, GAP_MAX);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            xfers++;
        end
    end

    initial
    begin
        table_row_t             rows[$];
        logic [TICKS_WIDTH-1:0] len;
        int                     tick_pct;
        int                     p;
        int                     n;
        int                     w;
        errors       = 0;
        items_sent   = 0;
        results_seen = 0;
        input_stalls = 0;
        cycles_done  = 0;
        cfg_writes   = 0;
        tx_burst     = 1'b0;
        m_cycle_len  = CYCLE_TICKS_RESET;
        m_auto       = 1'b1;
        m_manual     = '0;
        m_duty       = '0;
        for (n = 0; n < NUM_SWITCHES; n++)
        begin
            m_on[n]      = 1'b0;
            m_cycling[n] = 1'b0;
            m_elapsed[n] = '0;
        end
        rst_n              <= 1'b0;
        cfg_valid          <= 1'b0;
        power_cycle_ticks  <= CYCLE_TICKS_RESET;
        in_valid           <= 1'b0;
        kind               <= KIND_STATUS;
        switch_index       <= '0;
        device_command     <= '0;
        fan_mode           <= '0;
        manual_duty        <= '0;
        temperature_tenths <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, reset cycle length
        rows.push_back(row(KIND_STATUS, 0, 0, 0, 0, 0, 1,
                           status_word(1'b1, ACK_ACCEPTED, 0, 0, 0)));
        rows.push_back(row(KIND_TEMP, 0, 0, 0, 0, -16'sd32768, 1,
                           status_word(1'b0, ACK_ACCEPTED, 0, 0, 0)));
        rows.push_back(row(KIND_TEMP, 0, 0, 0, 0, 16'sd32767, 1,
                           status_word(1'b0, ACK_ACCEPTED, 0, DUTY_MAX, 8'd255)));
        rows.push_back(row(KIND_TEMP, 0, 0, 0, 0, 16'sd299, 1,
                           status_word(1'b0, ACK_ACCEPTED, 0, 0, 0)));
        rows.push_back(row(KIND_TEMP, 0, 0, 0, 0, 16'sd300, 0, '0));
        rows.push_back(row(KIND_TEMP, 0, 0, 0, 0, 16'sd400, 0, '0));
        rows.push_back(row(KIND_TEMP, 0, 0, 0, 0, 16'sd499, 0, '0));
        rows.push_back(row(KIND_TEMP, 0, 0, 0, 0, 16'sd500, 1,
                           status_word(1'b0, ACK_ACCEPTED, 0, DUTY_MAX, 8'd255)));
        rows.push_back(row(KIND_SET_DEVICE, 8'd255, CMD_ON, 0, 0, 0, 1,
                           status_word(1'b1, ACK_BAD_DEVICE, 0, DUTY_MAX, 8'd255)));
        rows.push_back(row(KIND_SET_DEVICE, 8'd3, CMD_CYCLE, 0, 0, 0, 1,
                           status_word(1'b1, ACK_BAD_DEVICE, 0, DUTY_MAX, 8'd255)));
        rows.push_back(row(KIND_SET_DEVICE, 8'd0, CMD_ON, 0, 0, 0, 0, '0));
        rows.push_back(row(KIND_SET_DEVICE, 8'd2, 8'd255, 0, 0, 0, 0, '0));
        rows.push_back(row(KIND_SET_DEVICE, 8'd2, CMD_ON, 0, 0, 0, 0, '0));
        rows.push_back(row(KIND_SET_DEVICE, 8'd1, CMD_CYCLE, 0, 0, 0, 0, '0));
        rows.push_back(row(KIND_TICK, 0, 0, 0, 0, 0, 0, '0));
        rows.push_back(row(KIND_SET_DEVICE, 8'd1, CMD_CYCLE, 0, 0, 0, 0, '0));
        rows.push_back(row(KIND_SET_DEVICE, 8'd1, CMD_OFF, 0, 0, 0, 0, '0));
        rows.push_back(row(KIND_SET_DEVICE, 8'd1, CMD_CYCLE, 0, 0, 0, 0, '0));
        rows.push_back(row(KIND_SET_FAN, 0, 0, 8'd255, 8'd255, 0, 0, '0));
        rows.push_back(row(KIND_TEMP, 0, 0, 0, 0, 16'sd0, 0, '0));
        rows.push_back(row(KIND_SET_FAN, 0, 0, 8'd1, 8'd0, 0, 0, '0));
        rows.push_back(row(KIND_TEMP, 0, 0, 0, 0, 16'sd450, 0, '0));
        rows.push_back(row(KIND_SET_FAN, 0, 0, FAN_MODE_CURVE, 8'd77, 0, 0, '0));
        rows.push_back(row(KIND_TEMP, 0, 0, 0, 0, 16'sd350, 0, '0));
        rows.push_back(row(KIND_SPARE_LO, 8'd0, CMD_ON, 8'd5, 8'd50, 16'sd480, 0, '0));
        foreach (rows[i])
            issue(rows[i].item, rows[i].known, rows[i].res);
        in_valid <= 1'b0;

        // random phases, one cycle length each
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin len = 16'd1;                        tick_pct = 30; end
                1:       begin len = 16'($urandom_range(2, 8));    tick_pct = 40; end
                2:       begin len = 16'd65535;                    tick_pct = 30; end
                3:       begin len = 16'($urandom_range(5, 12));   tick_pct = 60; end
                default: begin len = 16'd1;                        tick_pct = 20; end
            endcase
            write_cycle_len(len);
            for (n = 0; n < PHASE_ITEMS; n++)
                issue(random_item(tick_pct), 1'b0, '0);
            in_valid <= 1'b0;
        end

        for (w = 0; w < 2000 && pending_status.size() != 0; w++)
            @(posedge clk);
        if (pending_status.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_status.size()));
        repeat (8) @(posedge clk);

        $display("ran %0d items in %0d phases, %0d results checked, %0d cycles of input stall",
                 items_sent, PHASES, results_seen, input_stalls);
        $display("%0d cycle length writes, %0d timed power cycles completed, %0d mismatches",
                 cfg_writes, cycles_done, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("timeout with %0d results pending", pending_status.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/lsfc_pkg.sv
design/lsfc_switch_bank.sv
design/load_switch_and_fan_controller.sv
dv/tb_top.sv
